// ----- sv/jih_pkg.sv -----
// Shared types and constants for the joint intensity histogram block.
// No dependencies; all files but jih_count_mem use it by scoped names.
package jih_pkg;

    localparam int PIX_BITS   = 8;
    localparam int BIN_BITS   = 4;
    localparam int NBINS      = 16;
    localparam int POS_PORT_W = 20;
    localparam int QUAD_W     = 32;
    localparam int DIM_W      = 13;
    localparam int OUT_CNT_W  = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Advance strobes for the two interpolation stages.
    typedef struct packed {
        logic lerp_x;
        logic lerp_y;
    } stage_en_t;

endpackage

// ----- sv/jih_interp.sv -----
// Two-stage bilinear interpolator that turns one position and its pixel quad
// into an intensity bin. Depends on jih_pkg.
module jih_interp #(
    parameter int FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  jih_pkg::stage_en_t                en,
    input  logic [FRAC_BITS-1:0]              frac_x,
    input  logic [FRAC_BITS-1:0]              frac_y,
    input  logic [jih_pkg::QUAD_W-1:0]        quad,
    output logic [jih_pkg::BIN_BITS-1:0]      bin
);

    localparam int PB    = jih_pkg::PIX_BITS;
    localparam int TOP_W = PB + FRAC_BITS;
    localparam int SUM_W = PB + 2 * FRAC_BITS;

    logic [PB-1:0] tl, tr, bl, br;
    logic signed [PB:0]              d_top, d_bot;
    logic signed [FRAC_BITS:0]       fx_s, fy_s;
    logic signed [PB+FRAC_BITS+1:0]  p_top, p_bot;
    logic [TOP_W-1:0]                top_next, bot_next;
    logic [TOP_W-1:0]                top_reg, bot_reg;
    logic signed [TOP_W:0]           d_vert;
    logic signed [TOP_W+FRAC_BITS+1:0] p_vert;
    logic [SUM_W-1:0]                v_next;
    logic [jih_pkg::BIN_BITS-1:0]    bin_reg;

    assign tl = quad[PB-1:0];
    assign tr = quad[2*PB-1:PB];
    assign bl = quad[3*PB-1:2*PB];
    assign br = quad[4*PB-1:3*PB];

    // Each lerp is a + (b - a) * f; the true result is never negative and fits
    // in the target width, so modular addition gives it exactly.
    always_comb begin
        fx_s     = $signed({1'b0, frac_x});
        d_top    = $signed({1'b0, tr}) - $signed({1'b0, tl});
        d_bot    = $signed({1'b0, br}) - $signed({1'b0, bl});
        p_top    = d_top * fx_s;
        p_bot    = d_bot * fx_s;
        top_next = {tl, {FRAC_BITS{1'b0}}} + TOP_W'(p_top);
        bot_next = {bl, {FRAC_BITS{1'b0}}} + TOP_W'(p_bot);
    end

    always_comb begin
        fy_s   = $signed({1'b0, frac_y});
        d_vert = $signed({1'b0, bot_reg}) - $signed({1'b0, top_reg});
        p_vert = d_vert * fy_s;
        v_next = SUM_W'({top_reg, {FRAC_BITS{1'b0}}}) + SUM_W'(p_vert);
    end

    always_ff @(posedge aclk) begin
        if (en.lerp_x) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
        if (en.lerp_y) begin
            bin_reg <= v_next[SUM_W-1 -: jih_pkg::BIN_BITS];
        end
    end

    assign bin = bin_reg;

endmodule

// ----- sv/jih_count_mem.sv -----
// Count store: a synchronous memory with one read and one write port, a
// registered read and per-entry valid bits so that unwritten entries read zero.
// Depends on nothing outside this file.
module jih_count_mem #(
    parameter int ADDR_BITS = 8,
    parameter int WIDTH     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- sv/joint_intensity_histogram.sv -----
// Top level of the joint intensity histogram: command sequencer, bounds test
// and count update. Depends on jih_pkg, jih_interp and jih_count_mem.
//
// One command is handled at a time. A command is taken when s_ready is high;
// the sequencer then runs two interpolation stages, the histogram memory
// read, and the write-back of the incremented counts, and the next command is
// taken only after the write-back. The result register holds a finished
// transaction while the next command is already taken; only the write-back
// step waits for that register to drain. All counts come out of reset as zero
// at once, with no clearing pass. Image size registers are written through
// cfg_wr_en, cfg_wr_index (0 width, 1 height) and cfg_wr_data. The user must
// write them only while the block is idle; the block does not enforce it.
module joint_intensity_histogram #(
    parameter int COUNT_BITS     = 32,
    parameter int FRAC_BITS      = 8,
    parameter int COORD_INT_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [jih_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [jih_pkg::DIM_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [jih_pkg::POS_PORT_W-1:0]      s_pos_a_x,
    input  logic [jih_pkg::POS_PORT_W-1:0]      s_pos_a_y,
    input  logic [jih_pkg::QUAD_W-1:0]          s_quad_a,
    input  logic [jih_pkg::POS_PORT_W-1:0]      s_pos_b_x,
    input  logic [jih_pkg::POS_PORT_W-1:0]      s_pos_b_y,
    input  logic [jih_pkg::QUAD_W-1:0]          s_quad_b,
    input  logic [jih_pkg::BIN_BITS-1:0]        s_read_bin_a,
    input  logic [jih_pkg::BIN_BITS-1:0]        s_read_bin_b,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic [jih_pkg::BIN_BITS-1:0]        m_bin_a,
    output logic [jih_pkg::BIN_BITS-1:0]        m_bin_b,
    output logic [jih_pkg::OUT_CNT_W-1:0]       m_joint_count,
    output logic [jih_pkg::OUT_CNT_W-1:0]       m_row_count,
    output logic [jih_pkg::OUT_CNT_W-1:0]       m_col_count,
    output logic [jih_pkg::OUT_CNT_W-1:0]       m_total_count
);

    localparam int BB     = jih_pkg::BIN_BITS;
    localparam int PW     = jih_pkg::POS_PORT_W;
    localparam int DW     = jih_pkg::DIM_W;
    localparam int OW     = jih_pkg::OUT_CNT_W;
    localparam int POS_W  = COORD_INT_BITS + FRAC_BITS;
    localparam int USE_W  = (POS_W < PW) ? POS_W : PW;
    localparam int CMP_W  = (DW + FRAC_BITS > PW) ? DW + FRAC_BITS : PW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LERP_X = 3'd1;
    localparam logic [2:0] ST_LERP_Y = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [DW-1:0]         width_reg, height_reg;

    logic                  cmd_reg;
    logic [PW-1:0]         pos_a_x_reg, pos_a_y_reg, pos_b_x_reg, pos_b_y_reg;
    logic [jih_pkg::QUAD_W-1:0] quad_a_reg, quad_b_reg;
    logic [BB-1:0]         read_bin_a_reg, read_bin_b_reg;
    logic                  inside_reg, inside_next;
    logic [BB-1:0]         bin_a_sel_reg, bin_b_sel_reg;
    logic [BB-1:0]         bin_a_sel, bin_b_sel;
    logic [BB-1:0]         interp_bin_a, interp_bin_b;
    jih_pkg::stage_en_t    stage_en;

    logic [COUNT_BITS-1:0] joint_rd, row_rd, col_rd;
    logic [COUNT_BITS-1:0] joint_inc, row_inc, col_inc, total_inc;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  do_count, do_reject, out_free, wr_go, mem_wr_en;

    logic                  m_valid_reg, m_accepted_reg;
    logic [BB-1:0]         m_bin_a_reg, m_bin_b_reg;
    logic [OW-1:0]         m_joint_reg, m_row_reg, m_col_reg, m_total_reg;

    function automatic logic axis_inside(input logic [PW-1:0] p, input logic [DW-1:0] n);
        logic [CMP_W-1:0] pe;
        logic [CMP_W-1:0] lim;
        pe  = CMP_W'(p[USE_W-1:0]);
        lim = CMP_W'({DW'(n - 1'b1), {FRAC_BITS{1'b0}}});
        return (n != '0) && (pe != '0) && (pe < lim);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= jih_pkg::IMAGE_WIDTH_RESET;
            height_reg <= jih_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                jih_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                jih_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign wr_go    = (state_reg == ST_WRITE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_LERP_X;
            ST_LERP_X: state_next = ST_LERP_Y;
            ST_LERP_Y: state_next = ST_READ;
            ST_READ:   state_next = ST_WRITE;
            ST_WRITE:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command capture.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg        <= s_cmd;
            pos_a_x_reg    <= s_pos_a_x;
            pos_a_y_reg    <= s_pos_a_y;
            pos_b_x_reg    <= s_pos_b_x;
            pos_b_y_reg    <= s_pos_b_y;
            quad_a_reg     <= s_quad_a;
            quad_b_reg     <= s_quad_b;
            read_bin_a_reg <= s_read_bin_a;
            read_bin_b_reg <= s_read_bin_b;
        end
    end

    assign inside_next = axis_inside(pos_a_x_reg, width_reg)
                      && axis_inside(pos_a_y_reg, height_reg)
                      && axis_inside(pos_b_x_reg, width_reg)
                      && axis_inside(pos_b_y_reg, height_reg);

    assign stage_en.lerp_x = (state_reg == ST_LERP_X);
    assign stage_en.lerp_y = (state_reg == ST_LERP_Y);

    always_ff @(posedge aclk) begin
        if (stage_en.lerp_x) begin
            inside_reg <= inside_next;
        end
        if (state_reg == ST_READ) begin
            bin_a_sel_reg <= bin_a_sel;
            bin_b_sel_reg <= bin_b_sel;
        end
    end

    jih_interp #(.FRAC_BITS(FRAC_BITS)) u_interp_a (
        .aclk   (aclk),
        .en     (stage_en),
        .frac_x (pos_a_x_reg[FRAC_BITS-1:0]),
        .frac_y (pos_a_y_reg[FRAC_BITS-1:0]),
        .quad   (quad_a_reg),
        .bin    (interp_bin_a)
    );

    jih_interp #(.FRAC_BITS(FRAC_BITS)) u_interp_b (
        .aclk   (aclk),
        .en     (stage_en),
        .frac_x (pos_b_x_reg[FRAC_BITS-1:0]),
        .frac_y (pos_b_y_reg[FRAC_BITS-1:0]),
        .quad   (quad_b_reg),
        .bin    (interp_bin_b)
    );

    assign bin_a_sel = (cmd_reg == jih_pkg::CMD_READ) ? read_bin_a_reg : interp_bin_a;
    assign bin_b_sel = (cmd_reg == jih_pkg::CMD_READ) ? read_bin_b_reg : interp_bin_b;

    assign do_count  = (cmd_reg == jih_pkg::CMD_ACCUM) && inside_reg;
    assign do_reject = (cmd_reg == jih_pkg::CMD_ACCUM) && !inside_reg;
    assign mem_wr_en = wr_go && do_count;

    jih_count_mem #(.ADDR_BITS(2 * BB), .WIDTH(COUNT_BITS)) u_joint_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == ST_READ),
        .rd_addr ({bin_a_sel, bin_b_sel}),
        .rd_data (joint_rd),
        .wr_en   (mem_wr_en),
        .wr_addr ({bin_a_sel_reg, bin_b_sel_reg}),
        .wr_data (joint_inc)
    );

    jih_count_mem #(.ADDR_BITS(BB), .WIDTH(COUNT_BITS)) u_row_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (bin_a_sel),
        .rd_data (row_rd),
        .wr_en   (mem_wr_en),
        .wr_addr (bin_a_sel_reg),
        .wr_data (row_inc)
    );

    jih_count_mem #(.ADDR_BITS(BB), .WIDTH(COUNT_BITS)) u_col_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (bin_b_sel),
        .rd_data (col_rd),
        .wr_en   (mem_wr_en),
        .wr_addr (bin_b_sel_reg),
        .wr_data (col_inc)
    );

    assign joint_inc = sat_inc(joint_rd);
    assign row_inc   = sat_inc(row_rd);
    assign col_inc   = sat_inc(col_rd);
    assign total_inc = sat_inc(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (mem_wr_en) begin
            total_reg <= total_inc;
        end
    end

    // Result register; a rejected sample reports zeros and the unchanged total.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (wr_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_go) begin
            m_accepted_reg <= do_count;
            m_bin_a_reg    <= do_reject ? '0 : bin_a_sel_reg;
            m_bin_b_reg    <= do_reject ? '0 : bin_b_sel_reg;
            m_joint_reg    <= do_reject ? '0 : OW'(do_count ? joint_inc : joint_rd);
            m_row_reg      <= do_reject ? '0 : OW'(do_count ? row_inc : row_rd);
            m_col_reg      <= do_reject ? '0 : OW'(do_count ? col_inc : col_rd);
            m_total_reg    <= OW'(do_count ? total_inc : total_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_bin_a       = m_bin_a_reg;
    assign m_bin_b       = m_bin_b_reg;
    assign m_joint_count = m_joint_reg;
    assign m_row_count   = m_row_reg;
    assign m_col_count   = m_col_reg;
    assign m_total_count = m_total_reg;

endmodule

// ----- sv/jih_checker.sv -----
// Port-level checks for the joint intensity histogram, bound to the top level.
// Depends on jih_pkg and joint_intensity_histogram.
module jih_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_accepted,
    input logic [jih_pkg::BIN_BITS-1:0]   m_bin_a,
    input logic [jih_pkg::BIN_BITS-1:0]   m_bin_b,
    input logic [jih_pkg::OUT_CNT_W-1:0]  m_joint_count,
    input logic [jih_pkg::OUT_CNT_W-1:0]  m_row_count,
    input logic [jih_pkg::OUT_CNT_W-1:0]  m_col_count,
    input logic [jih_pkg::OUT_CNT_W-1:0]  m_total_count
);

    // A stalled result transaction keeps its bins, joint count and total count.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_a) && $stable(m_bin_b)
            && $stable(m_joint_count) && $stable(m_total_count))
        else $error("result changed while stalled");

    // A joint bin never exceeds its marginals, nor a marginal the total.
    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_joint_count <= m_row_count && m_joint_count <= m_col_count
            && m_row_count <= m_total_count && m_col_count <= m_total_count)
        else $error("count ordering broken");

    // A counted sample shows a nonzero joint count and a nonzero total.
    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_joint_count != 0 && m_total_count != 0)
        else $error("counted sample reports a zero count");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind joint_intensity_histogram jih_checker u_jih_checker (.*);
